>>> hdl/hftsu_pkg.sv
// Shared types, codes and the micro-program of the hourly thermal step unit.
`default_nettype none

package hftsu_pkg;

  // Micro-operations executed by the sequencer
  typedef enum logic [3:0] {
    OP_LDI,   // load a constant, register or input field into a slot
    OP_MOV,
    OP_ADD,   // saturating add
    OP_SUB,   // saturating subtract
    OP_MUL,   // rounded fixed-point product
    OP_DIV,   // rounded fixed-point quotient, zero divisor flags an error
    OP_CMPH,  // heat flag <= a < b
    OP_CMPC,  // cool flag <= a < b
    OP_SEL,   // dst <= heat flag ? a : b
    OP_OUTF,  // result field (dst) <= saturated a
    OP_BRF,   // branch to output when free floating
    OP_END
  } op_e;

  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned NUM_SLOTS = 32;
  localparam int unsigned PC_W      = 8;
  localparam int unsigned VAL_W     = 64;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PC_W-1:0]   pc_t;

  typedef struct packed {
    op_e   op;
    slot_t dst;
    slot_t a;
    slot_t b;
  } instr_t;

  // Scratch slots
  localparam slot_t R_HVE  = 5'd0;
  localparam slot_t R_HIS  = 5'd1;
  localparam slot_t R_HW   = 5'd2;
  localparam slot_t R_HMS  = 5'd3;
  localparam slot_t R_HEM  = 5'd4;
  localparam slot_t R_TE   = 5'd5;
  localparam slot_t R_TSUP = 5'd6;
  localparam slot_t R_HS   = 5'd7;
  localparam slot_t R_CS   = 5'd8;
  localparam slot_t R_H1   = 5'd9;
  localparam slot_t R_H2   = 5'd10;
  localparam slot_t R_H3   = 5'd11;
  localparam slot_t R_CM   = 5'd12;
  localparam slot_t R_PIA  = 5'd13;
  localparam slot_t R_PM   = 5'd14;
  localparam slot_t R_PST  = 5'd15;
  localparam slot_t R_PW   = 5'd16;
  localparam slot_t R_PREV = 5'd17;
  localparam slot_t R_T0   = 5'd18;
  localparam slot_t R_T1   = 5'd19;
  localparam slot_t R_T2   = 5'd20;
  localparam slot_t R_T3   = 5'd21;
  localparam slot_t R_TMT  = 5'd22;
  localparam slot_t R_TM   = 5'd23;
  localparam slot_t R_TS   = 5'd24;
  localparam slot_t R_TA   = 5'd25;
  localparam slot_t R_A0   = 5'd26;
  localparam slot_t R_SET  = 5'd27;
  localparam slot_t R_P10  = 5'd28;
  localparam slot_t R_P    = 5'd29;
  localparam slot_t R_HALF = 5'd30;
  localparam slot_t R_T4   = 5'd31;
  localparam slot_t R_NONE = 5'd0;

  // Load sources
  localparam slot_t S_ZERO = 5'd0;
  localparam slot_t S_HVE  = 5'd1;
  localparam slot_t S_TE   = 5'd2;
  localparam slot_t S_TSUP = 5'd3;
  localparam slot_t S_HS   = 5'd4;
  localparam slot_t S_CS   = 5'd5;
  localparam slot_t S_IG   = 5'd6;
  localparam slot_t S_SG   = 5'd7;
  localparam slot_t S_HIS  = 5'd8;
  localparam slot_t S_HW   = 5'd9;
  localparam slot_t S_HMS  = 5'd10;
  localparam slot_t S_HEM  = 5'd11;
  localparam slot_t S_HC   = 5'd12;
  localparam slot_t S_AM   = 5'd13;
  localparam slot_t S_AT   = 5'd14;
  localparam slot_t S_FA   = 5'd15;
  localparam slot_t S_MASS = 5'd16;
  localparam slot_t S_HALF = 5'd17;
  localparam slot_t S_NINE = 5'd18;
  localparam slot_t S_ONE  = 5'd19;
  localparam slot_t S_CDIV = 5'd20;
  localparam slot_t S_TEN  = 5'd21;

  // Result field codes for OP_OUTF
  localparam slot_t OF_AIR  = 5'd0;
  localparam slot_t OF_SURF = 5'd1;
  localparam slot_t OF_MEAN = 5'd2;
  localparam slot_t OF_END  = 5'd3;
  localparam slot_t OF_POW  = 5'd4;

  // Result modes
  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_COOL = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEM  = 3'd0;
  localparam logic [2:0] CFG_HIS  = 3'd1;
  localparam logic [2:0] CFG_HW   = 3'd2;
  localparam logic [2:0] CFG_HMS  = 3'd3;
  localparam logic [2:0] CFG_HC   = 3'd4;
  localparam logic [2:0] CFG_AM   = 3'd5;
  localparam logic [2:0] CFG_AT   = 3'd6;
  localparam logic [2:0] CFG_FA   = 3'd7;

  // Program layout
  localparam pc_t PC_SOLVE0 = 8'd38;
  localparam pc_t PC_TAIL0  = 8'd70;
  localparam pc_t PC_SOLVE1 = 8'd79;
  localparam pc_t PC_MID    = 8'd111;
  localparam pc_t PC_SOLVE2 = 8'd116;
  localparam pc_t PC_OUT    = 8'd148;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    slot_t      raddr;
    logic       lat_a;
    logic       lat_b;
    logic       start;
    op_e        op;
    slot_t      dst;
    slot_t      src;
    logic       commit;
    logic       commit_err;
    logic [1:0] mode;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic err;
    logic flag_h;
    logic flag_c;
    logic out_free;
  } dp_sts_t;

  function automatic instr_t mk(op_e op, slot_t d, slot_t a, slot_t b);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.a   = a;
    i.b   = b;
    return i;
  endfunction

  // Coupling conductances, gains split and heat capacity per hour
  function automatic instr_t prologue_op(pc_t k);
    instr_t i;
    unique case (k)
      8'd0:  i = mk(OP_LDI, R_HVE,  S_HVE,  R_NONE);
      8'd1:  i = mk(OP_LDI, R_HIS,  S_HIS,  R_NONE);
      8'd2:  i = mk(OP_LDI, R_HW,   S_HW,   R_NONE);
      8'd3:  i = mk(OP_LDI, R_HMS,  S_HMS,  R_NONE);
      8'd4:  i = mk(OP_LDI, R_HEM,  S_HEM,  R_NONE);
      8'd5:  i = mk(OP_LDI, R_TE,   S_TE,   R_NONE);
      8'd6:  i = mk(OP_LDI, R_TSUP, S_TSUP, R_NONE);
      8'd7:  i = mk(OP_LDI, R_HS,   S_HS,   R_NONE);
      8'd8:  i = mk(OP_LDI, R_CS,   S_CS,   R_NONE);
      8'd9:  i = mk(OP_LDI, R_PREV, S_MASS, R_NONE);
      8'd10: i = mk(OP_LDI, R_HALF, S_HALF, R_NONE);
      8'd11: i = mk(OP_LDI, R_P,    S_ZERO, R_NONE);
      8'd12: i = mk(OP_LDI, R_PW,   S_ZERO, R_NONE);
      8'd13: i = mk(OP_ADD, R_T0,   R_HVE,  R_HIS);
      8'd14: i = mk(OP_MUL, R_T1,   R_HVE,  R_HIS);
      8'd15: i = mk(OP_DIV, R_H1,   R_T1,   R_T0);
      8'd16: i = mk(OP_ADD, R_H2,   R_H1,   R_HW);
      8'd17: i = mk(OP_ADD, R_T0,   R_H2,   R_HMS);
      8'd18: i = mk(OP_MUL, R_T1,   R_H2,   R_HMS);
      8'd19: i = mk(OP_DIV, R_H3,   R_T1,   R_T0);
      8'd20: i = mk(OP_LDI, R_T0,   S_AT,   R_NONE);
      8'd21: i = mk(OP_LDI, R_T1,   S_NINE, R_NONE);
      8'd22: i = mk(OP_MUL, R_T1,   R_T1,   R_T0);
      8'd23: i = mk(OP_LDI, R_T2,   S_IG,   R_NONE);
      8'd24: i = mk(OP_MUL, R_PIA,  R_HALF, R_T2);
      8'd25: i = mk(OP_LDI, R_T2,   S_SG,   R_NONE);
      8'd26: i = mk(OP_ADD, R_T2,   R_PIA,  R_T2);
      8'd27: i = mk(OP_LDI, R_T3,   S_AM,   R_NONE);
      8'd28: i = mk(OP_DIV, R_T3,   R_T3,   R_T0);
      8'd29: i = mk(OP_DIV, R_T1,   R_HW,   R_T1);
      8'd30: i = mk(OP_MUL, R_PM,   R_T3,   R_T2);
      8'd31: i = mk(OP_LDI, R_T4,   S_ONE,  R_NONE);
      8'd32: i = mk(OP_SUB, R_T4,   R_T4,   R_T3);
      8'd33: i = mk(OP_SUB, R_T4,   R_T4,   R_T1);
      8'd34: i = mk(OP_MUL, R_PST,  R_T4,   R_T2);
      8'd35: i = mk(OP_LDI, R_T0,   S_HC,   R_NONE);
      8'd36: i = mk(OP_LDI, R_T1,   S_CDIV, R_NONE);
      8'd37: i = mk(OP_DIV, R_CM,   R_T0,   R_T1);
      default: i = mk(OP_END, R_NONE, R_NONE, R_NONE);
    endcase
    return i;
  endfunction

  // One network evaluation with power in R_PW
  function automatic instr_t solve_op(pc_t k);
    instr_t i;
    unique case (k)
      8'd0:  i = mk(OP_ADD, R_T4,  R_PIA,  R_PW);
      8'd1:  i = mk(OP_DIV, R_T0,  R_T4,   R_HVE);
      8'd2:  i = mk(OP_MUL, R_T1,  R_HW,   R_TE);
      8'd3:  i = mk(OP_ADD, R_T1,  R_PST,  R_T1);
      8'd4:  i = mk(OP_ADD, R_T2,  R_TSUP, R_T0);
      8'd5:  i = mk(OP_MUL, R_T2,  R_H1,   R_T2);
      8'd6:  i = mk(OP_ADD, R_T1,  R_T1,   R_T2);
      8'd7:  i = mk(OP_MUL, R_T2,  R_HEM,  R_TE);
      8'd8:  i = mk(OP_ADD, R_T2,  R_PM,   R_T2);
      8'd9:  i = mk(OP_DIV, R_T3,  R_T1,   R_H2);
      8'd10: i = mk(OP_MUL, R_T3,  R_H3,   R_T3);
      8'd11: i = mk(OP_ADD, R_T2,  R_T2,   R_T3);
      8'd12: i = mk(OP_ADD, R_T3,  R_H3,   R_HEM);
      8'd13: i = mk(OP_MUL, R_T3,  R_HALF, R_T3);
      8'd14: i = mk(OP_ADD, R_T0,  R_CM,   R_T3);
      8'd15: i = mk(OP_SUB, R_T3,  R_CM,   R_T3);
      8'd16: i = mk(OP_MUL, R_T3,  R_PREV, R_T3);
      8'd17: i = mk(OP_ADD, R_T3,  R_T3,   R_T2);
      8'd18: i = mk(OP_DIV, R_TMT, R_T3,   R_T0);
      8'd19: i = mk(OP_ADD, R_T0,  R_TMT,  R_PREV);
      8'd20: i = mk(OP_MUL, R_TM,  R_HALF, R_T0);
      8'd21: i = mk(OP_ADD, R_T0,  R_HMS,  R_HW);
      8'd22: i = mk(OP_ADD, R_T0,  R_T0,   R_H1);
      8'd23: i = mk(OP_MUL, R_T2,  R_HMS,  R_TM);
      8'd24: i = mk(OP_ADD, R_T2,  R_T2,   R_T1);
      8'd25: i = mk(OP_DIV, R_TS,  R_T2,   R_T0);
      8'd26: i = mk(OP_ADD, R_T0,  R_HIS,  R_HVE);
      8'd27: i = mk(OP_MUL, R_T1,  R_HIS,  R_TS);
      8'd28: i = mk(OP_MUL, R_T2,  R_HVE,  R_TSUP);
      8'd29: i = mk(OP_ADD, R_T1,  R_T1,   R_T2);
      8'd30: i = mk(OP_ADD, R_T1,  R_T1,   R_T4);
      8'd31: i = mk(OP_DIV, R_TA,  R_T1,   R_T0);
      default: i = mk(OP_END, R_NONE, R_NONE, R_NONE);
    endcase
    return i;
  endfunction

  // Setpoint test, trial power, interpolation and result output
  function automatic instr_t tail_op(pc_t k);
    instr_t i;
    unique case (k)
      8'd70:  i = mk(OP_MOV,  R_A0,    R_TA,   R_NONE);
      8'd71:  i = mk(OP_CMPH, R_NONE,  R_TA,   R_HS);
      8'd72:  i = mk(OP_CMPC, R_NONE,  R_CS,   R_TA);
      8'd73:  i = mk(OP_BRF,  R_NONE,  R_NONE, R_NONE);
      8'd74:  i = mk(OP_SEL,  R_SET,   R_HS,   R_CS);
      8'd75:  i = mk(OP_LDI,  R_T0,    S_TEN,  R_NONE);
      8'd76:  i = mk(OP_LDI,  R_T1,    S_FA,   R_NONE);
      8'd77:  i = mk(OP_MUL,  R_P10,   R_T0,   R_T1);
      8'd78:  i = mk(OP_MOV,  R_PW,    R_P10,  R_NONE);
      8'd111: i = mk(OP_SUB,  R_T0,    R_TA,   R_A0);
      8'd112: i = mk(OP_SUB,  R_T1,    R_SET,  R_A0);
      8'd113: i = mk(OP_DIV,  R_T1,    R_T1,   R_T0);
      8'd114: i = mk(OP_MUL,  R_P,     R_P10,  R_T1);
      8'd115: i = mk(OP_MOV,  R_PW,    R_P,    R_NONE);
      8'd148: i = mk(OP_OUTF, OF_AIR,  R_TA,   R_NONE);
      8'd149: i = mk(OP_OUTF, OF_SURF, R_TS,   R_NONE);
      8'd150: i = mk(OP_OUTF, OF_MEAN, R_TM,   R_NONE);
      8'd151: i = mk(OP_OUTF, OF_END,  R_TMT,  R_NONE);
      8'd152: i = mk(OP_OUTF, OF_POW,  R_P,    R_NONE);
      default: i = mk(OP_END, R_NONE, R_NONE, R_NONE);
    endcase
    return i;
  endfunction

  function automatic instr_t prog(pc_t pc);
    instr_t i;
    priority if (pc < PC_SOLVE0) begin
      i = prologue_op(pc);
    end else if (pc < PC_TAIL0) begin
      i = solve_op(pc - PC_SOLVE0);
    end else if (pc < PC_SOLVE1) begin
      i = tail_op(pc);
    end else if (pc < PC_MID) begin
      i = solve_op(pc - PC_SOLVE1);
    end else if (pc < PC_SOLVE2) begin
      i = tail_op(pc);
    end else if (pc < PC_OUT) begin
      i = solve_op(pc - PC_SOLVE2);
    end else begin
      i = tail_op(pc);
    end
    return i;
  endfunction

endpackage

`default_nettype wire

>>> hdl/hourly_five_node_thermal_step_unit.sv
// Top level of the hourly five-node thermal step unit.
//
// Each input transfer is one simulated hour of a 5R1C zone model. The block
// runs a fixed micro-program on one slot RAM, one saturating adder, one
// multiplier that takes four 32x32 partial products and then rounds, and
// one restoring divider that produces one quotient bit a cycle. Every
// micro-op reads its operands from the slot RAM before it issues. An hour
// that needs heating or cooling takes longer than a free-floating hour,
// with the divider setting most of the time.
// A new input is taken once the previous hour has moved into the output
// register, which holds its result until transferred. Any zero divisor ends
// the hour with mode 3, zero fields and the mass temperature unchanged.
`default_nettype none

module hourly_five_node_thermal_step_unit import hftsu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [39:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [31:0]        vent_conductance_i,
  input  wire logic [47:0]        internal_gain_i,
  input  wire logic [47:0]        solar_gain_i,
  input  wire logic signed [31:0] outdoor_temp_i,
  input  wire logic signed [31:0] supply_temp_i,
  input  wire logic signed [31:0] heat_setpoint_i,
  input  wire logic signed [31:0] cool_setpoint_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      air_temp_o,
  output logic signed [31:0]      surface_temp_o,
  output logic signed [31:0]      mass_temp_mean_o,
  output logic signed [31:0]      mass_temp_end_o,
  output logic signed [47:0]      hc_power_o,
  output logic [1:0]              mode_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hftsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hftsu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .vent_conductance_i (vent_conductance_i),
    .internal_gain_i    (internal_gain_i),
    .solar_gain_i       (solar_gain_i),
    .outdoor_temp_i     (outdoor_temp_i),
    .supply_temp_i      (supply_temp_i),
    .heat_setpoint_i    (heat_setpoint_i),
    .cool_setpoint_i    (cool_setpoint_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .air_temp_o         (air_temp_o),
    .surface_temp_o     (surface_temp_o),
    .mass_temp_mean_o   (mass_temp_mean_o),
    .mass_temp_end_o    (mass_temp_end_o),
    .hc_power_o         (hc_power_o),
    .mode_o             (mode_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

`default_nettype wire

>>> hdl/hftsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hftsu_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/hftsu_datapath.sv
// Datapath: config and input registers, slot RAM, ALU, multiplier, divider, results.
`default_nettype none

module hftsu_datapath import hftsu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [39:0]        cfg_data_i,
  input  wire logic [31:0]        vent_conductance_i,
  input  wire logic [47:0]        internal_gain_i,
  input  wire logic [47:0]        solar_gain_i,
  input  wire logic signed [31:0] outdoor_temp_i,
  input  wire logic signed [31:0] supply_temp_i,
  input  wire logic signed [31:0] heat_setpoint_i,
  input  wire logic signed [31:0] cool_setpoint_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      air_temp_o,
  output logic signed [31:0]      surface_temp_o,
  output logic signed [31:0]      mass_temp_mean_o,
  output logic signed [31:0]      mass_temp_end_o,
  output logic signed [47:0]      hc_power_o,
  output logic [1:0]              mode_o,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o
);

  localparam logic signed [63:0] LIM      = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_Q   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] TEN_Q    = 64'sd10 <<< FRAC_BITS;
  localparam logic signed [63:0] NINE_Q   = 64'(((64'd91 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [63:0] CDIV_Q   = 64'sd3600;
  localparam logic signed [31:0] MASS_RST = 32'(22 << FRAC_BITS);
  localparam int unsigned        DVW      = 64 + FRAC_BITS;
  localparam int unsigned        DCW      = $clog2(DVW);

  // Config registers
  logic [31:0] hem_q, his_q, hw_q, hms_q, am_q, at_q, fa_q;
  logic [39:0] hc_q;

  // Mass state, completion, error and setpoint flags
  logic signed [31:0] mass_q;
  logic               done_q, err_q, flag_h_q, flag_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hem_q <= 32'd163840;
      his_q <= 32'd1343488;
      hw_q  <= 32'd163840;
      hms_q <= 32'd1343488;
      hc_q  <= 40'd4125000;
      am_q  <= 32'd4096000;
      at_q  <= 32'd7372800;
      fa_q  <= 32'd1638400;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEM: hem_q <= cfg_data_i[31:0];
        CFG_HIS: his_q <= cfg_data_i[31:0];
        CFG_HW:  hw_q  <= cfg_data_i[31:0];
        CFG_HMS: hms_q <= cfg_data_i[31:0];
        CFG_HC:  hc_q  <= cfg_data_i;
        CFG_AM:  am_q  <= cfg_data_i[31:0];
        CFG_AT:  at_q  <= cfg_data_i[31:0];
        CFG_FA:  fa_q  <= cfg_data_i[31:0];
      endcase
    end
  end

  // Input item, held for the whole hour step
  logic [31:0] hve_q;
  logic [47:0] ig_q, sg_q;
  logic [31:0] te_q, tsup_q, hs_q, cs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      hve_q  <= vent_conductance_i;
      ig_q   <= internal_gain_i;
      sg_q   <= solar_gain_i;
      te_q   <= outdoor_temp_i;
      tsup_q <= supply_temp_i;
      hs_q   <= heat_setpoint_i;
      cs_q   <= cool_setpoint_i;
    end
  end

  // Slot RAM and operand latches
  logic               wr_en;
  slot_t              wr_addr;
  logic signed [63:0] wr_data;
  logic [63:0]        rd_data;
  logic signed [63:0] opa_q, opb_q;

  hftsu_ram #(.WIDTH(VAL_W), .DEPTH(NUM_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (cmd_i.raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) begin
      opa_q <= rd_data;
    end
    if (cmd_i.lat_b) begin
      opb_q <= rd_data;
    end
  end

  function automatic logic signed [63:0] clampq(logic signed [63:0] v);
    if (v > LIM) begin
      return LIM;
    end else if (v < -LIM) begin
      return -LIM;
    end
    return v;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Load source selection
  logic signed [63:0] src_val;
  always_comb begin
    unique case (cmd_i.src)
      S_HVE:   src_val = {32'd0, hve_q};
      S_TE:    src_val = {{32{te_q[31]}}, te_q};
      S_TSUP:  src_val = {{32{tsup_q[31]}}, tsup_q};
      S_HS:    src_val = {{32{hs_q[31]}}, hs_q};
      S_CS:    src_val = {{32{cs_q[31]}}, cs_q};
      S_IG:    src_val = {16'd0, ig_q};
      S_SG:    src_val = {16'd0, sg_q};
      S_HIS:   src_val = {32'd0, his_q};
      S_HW:    src_val = {32'd0, hw_q};
      S_HMS:   src_val = {32'd0, hms_q};
      S_HEM:   src_val = {32'd0, hem_q};
      S_HC:    src_val = {24'd0, hc_q};
      S_AM:    src_val = {32'd0, am_q};
      S_AT:    src_val = {32'd0, at_q};
      S_FA:    src_val = {32'd0, fa_q};
      S_MASS:  src_val = {{32{mass_q[31]}}, mass_q};
      S_HALF:  src_val = HALF_Q;
      S_NINE:  src_val = NINE_Q;
      S_ONE:   src_val = ONE_Q;
      S_CDIV:  src_val = CDIV_Q;
      S_TEN:   src_val = TEN_Q;
      default: src_val = '0;
    endcase
  end

  // Simple operations, written back as they issue
  logic               simple_wr;
  logic signed [63:0] simple_res;
  always_comb begin
    simple_wr  = 1'b0;
    simple_res = opa_q;
    if (cmd_i.start) begin
      unique case (cmd_i.op)
        OP_LDI: begin simple_wr = 1'b1; simple_res = src_val; end
        OP_MOV: begin simple_wr = 1'b1; simple_res = opa_q; end
        OP_ADD: begin simple_wr = 1'b1; simple_res = clampq(opa_q + opb_q); end
        OP_SUB: begin simple_wr = 1'b1; simple_res = clampq(opa_q - opb_q); end
        OP_SEL: begin simple_wr = 1'b1; simple_res = flag_h_q ? opa_q : opb_q; end
        default: ;
      endcase
    end
  end

  // Multiplier: four 32x32 partial products, then round and clamp
  logic               mul_run_q;
  logic [2:0]         mul_cnt_q;
  logic [63:0]        mul_a_q, mul_b_q;
  logic [127:0]       mul_acc_q;
  logic               mul_neg_q;
  logic [31:0]        mul_pa, mul_pb;
  logic [63:0]        mul_pp;
  logic [127:0]       mul_sh, mul_q;
  logic [63:0]        mul_mag;
  logic               mul_fin;
  logic signed [63:0] mul_res;

  always_comb begin
    mul_pa = mul_cnt_q[0] ? mul_a_q[63:32] : mul_a_q[31:0];
    mul_pb = mul_cnt_q[1] ? mul_b_q[63:32] : mul_b_q[31:0];
    mul_pp = mul_pa * mul_pb;
    unique case (mul_cnt_q[1:0])
      2'd0:    mul_sh = {64'd0, mul_pp};
      2'd3:    mul_sh = {mul_pp, 64'd0};
      default: mul_sh = {32'd0, mul_pp, 32'd0};
    endcase
    mul_q   = (mul_acc_q + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_mag = (mul_q > 128'(LIM)) ? 64'(LIM) : mul_q[63:0];
    mul_res = mul_neg_q ? -$signed(mul_mag) : $signed(mul_mag);
    mul_fin = mul_run_q && mul_cnt_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_run_q <= 1'b0;
      mul_cnt_q <= '0;
    end else if (cmd_i.start && cmd_i.op == OP_MUL) begin
      mul_run_q <= 1'b1;
      mul_cnt_q <= '0;
    end else if (mul_fin) begin
      mul_run_q <= 1'b0;
    end else if (mul_run_q) begin
      mul_cnt_q <= mul_cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && cmd_i.op == OP_MUL) begin
      mul_a_q   <= mag(opa_q);
      mul_b_q   <= mag(opb_q);
      mul_neg_q <= opa_q[63] ^ opb_q[63];
      mul_acc_q <= '0;
    end else if (mul_run_q && !mul_cnt_q[2]) begin
      mul_acc_q <= mul_acc_q + mul_sh;
    end
  end

  // Divider: restoring, one quotient bit a cycle, then round and clamp
  logic               div_run_q, div_last_q;
  logic [DCW-1:0]     div_cnt_q;
  logic [DVW-1:0]     div_num_q, div_quo_q;
  logic [63:0]        div_rem_q, div_den_q;
  logic               div_neg_q;
  logic [63:0]        div_try;
  logic               div_ge;
  logic [DVW-1:0]     div_qr, div_mag;
  logic signed [63:0] div_res;
  logic               div_go, div_zero;

  assign div_go   = cmd_i.start && cmd_i.op == OP_DIV && opb_q != 64'sd0;
  assign div_zero = cmd_i.start && cmd_i.op == OP_DIV && opb_q == 64'sd0;

  always_comb begin
    div_try = {div_rem_q[62:0], div_num_q[DVW-1]};
    div_ge  = div_try >= div_den_q;
    div_qr  = div_quo_q + DVW'(({div_rem_q, 1'b0} >= {1'b0, div_den_q}) ? 1 : 0);
    div_mag = (div_qr > DVW'(LIM)) ? DVW'(LIM) : div_qr;
    div_res = div_neg_q ? -$signed(div_mag[63:0]) : $signed(div_mag[63:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q  <= 1'b0;
      div_last_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_go) begin
      div_run_q  <= 1'b1;
      div_last_q <= 1'b0;
      div_cnt_q  <= DCW'(DVW - 1);
    end else if (div_last_q) begin
      div_last_q <= 1'b0;
    end else if (div_run_q) begin
      if (div_cnt_q == '0) begin
        div_run_q  <= 1'b0;
        div_last_q <= 1'b1;
      end
      div_cnt_q <= div_cnt_q - DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      div_num_q <= DVW'(mag(opa_q)) << FRAC_BITS;
      div_den_q <= mag(opb_q);
      div_neg_q <= opa_q[63] ^ opb_q[63];
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (div_run_q) begin
      div_num_q <= div_num_q << 1;
      div_rem_q <= div_ge ? div_try - div_den_q : div_try;
      div_quo_q <= {div_quo_q[DVW-2:0], div_ge};
    end
  end

  // Slot write-back
  slot_t unit_dst_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      unit_dst_q <= cmd_i.dst;
    end
  end

  always_comb begin
    wr_en   = simple_wr || mul_fin || div_last_q;
    wr_addr = simple_wr ? cmd_i.dst : unit_dst_q;
    priority if (mul_fin) begin
      wr_data = mul_res;
    end else if (div_last_q) begin
      wr_data = div_res;
    end else begin
      wr_data = simple_res;
    end
  end

  // Completion, error and setpoint flags
  logic simple_done;
  assign simple_done = cmd_i.start && cmd_i.op != OP_MUL && cmd_i.op != OP_DIV;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      err_q    <= 1'b0;
      flag_h_q <= 1'b0;
      flag_c_q <= 1'b0;
    end else begin
      done_q <= simple_done || mul_fin || div_last_q || div_zero;
      if (cmd_i.load_in) begin
        err_q    <= 1'b0;
        flag_h_q <= 1'b0;
        flag_c_q <= 1'b0;
      end else begin
        if (div_zero) begin
          err_q <= 1'b1;
        end
        if (cmd_i.start && cmd_i.op == OP_CMPH) begin
          flag_h_q <= opa_q < opb_q;
        end
        if (cmd_i.start && cmd_i.op == OP_CMPC) begin
          flag_c_q <= opa_q < opb_q;
        end
      end
    end
  end

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -64'sh8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  // Result staging
  logic signed [31:0] st_air_q, st_surf_q, st_mean_q, st_end_q;
  logic signed [47:0] st_pow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && cmd_i.op == OP_OUTF) begin
      unique case (cmd_i.dst)
        OF_AIR:  st_air_q  <= sat32(opa_q);
        OF_SURF: st_surf_q <= sat32(opa_q);
        OF_MEAN: st_mean_q <= sat32(opa_q);
        OF_END:  st_end_q  <= sat32(opa_q);
        OF_POW:  st_pow_q  <= sat48(opa_q);
        default: ;
      endcase
    end
  end

  // Mass state and output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= MASS_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        mass_q <= st_end_q;
      end
      if (cmd_i.commit || cmd_i.commit_err) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      air_temp_o       <= st_air_q;
      surface_temp_o   <= st_surf_q;
      mass_temp_mean_o <= st_mean_q;
      mass_temp_end_o  <= st_end_q;
      hc_power_o       <= st_pow_q;
      mode_o           <= cmd_i.mode;
    end else if (cmd_i.commit_err) begin
      air_temp_o       <= '0;
      surface_temp_o   <= '0;
      mass_temp_mean_o <= '0;
      mass_temp_end_o  <= '0;
      hc_power_o       <= '0;
      mode_o           <= MODE_ERR;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.done      = done_q;
  assign sts_o.err       = err_q;
  assign sts_o.flag_h    = flag_h_q;
  assign sts_o.flag_c    = flag_c_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

>>> hdl/hftsu_ctrl.sv
// Controller: micro-program sequencer driving the datapath.
`default_nettype none

module hftsu_ctrl import hftsu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_LATB,
    ST_GO,
    ST_WAIT,
    ST_FIN,
    ST_FAIL
  } state_e;

  state_e state_q;
  pc_t    pc_q;
  instr_t ins;
  logic   take;

  assign ins        = prog(pc_q);
  assign in_stall_o = state_q != ST_IDLE;
  assign take       = in_valid_i && state_q == ST_IDLE;

  // Commands to the datapath
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_in    = take;
    cmd_o.raddr      = (state_q == ST_RDB) ? ins.b : ins.a;
    cmd_o.lat_a      = state_q == ST_RDB;
    cmd_o.lat_b      = state_q == ST_LATB;
    cmd_o.start      = state_q == ST_GO;
    cmd_o.op         = ins.op;
    cmd_o.dst        = ins.dst;
    cmd_o.src        = ins.a;
    cmd_o.commit     = state_q == ST_FIN && sts_i.out_free;
    cmd_o.commit_err = state_q == ST_FAIL && sts_i.out_free;
    priority if (sts_i.flag_h) begin
      cmd_o.mode = MODE_HEAT;
    end else if (sts_i.flag_c) begin
      cmd_o.mode = MODE_COOL;
    end else begin
      cmd_o.mode = MODE_FREE;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            pc_q    <= '0;
            state_q <= ST_RDA;
          end
        end
        ST_RDA: begin
          if (ins.op == OP_BRF) begin
            pc_q <= (!sts_i.flag_h && !sts_i.flag_c) ? PC_OUT : pc_q + 8'd1;
          end else if (ins.op == OP_END) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_RDB;
          end
        end
        ST_RDB:  state_q <= ST_LATB;
        ST_LATB: state_q <= ST_GO;
        ST_GO:   state_q <= ST_WAIT;
        ST_WAIT: begin
          if (sts_i.done) begin
            if (sts_i.err) begin
              state_q <= ST_FAIL;
            end else begin
              pc_q    <= pc_q + 8'd1;
              state_q <= ST_RDA;
            end
          end
        end
        ST_FIN, ST_FAIL: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/hftsu_checker.sv
// Port-level checks for the thermal step unit, bound to the top level.
`default_nettype none

module hftsu_checker import hftsu_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] air_temp_o,
  input wire logic signed [31:0] surface_temp_o,
  input wire logic signed [31:0] mass_temp_mean_o,
  input wire logic signed [31:0] mass_temp_end_o,
  input wire logic signed [47:0] hc_power_o,
  input wire logic [1:0]         mode_o
);

  // An accepted hour keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // Free-floating hours report no power
  a_free_no_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == MODE_FREE |-> hc_power_o == 48'sd0)
    else $error("power reported in free-floating mode");

  // Error results carry only zeros
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == MODE_ERR |-> air_temp_o == 32'sd0 &&
      surface_temp_o == 32'sd0 && mass_temp_mean_o == 32'sd0 &&
      mass_temp_end_o == 32'sd0 && hc_power_o == 48'sd0)
    else $error("nonzero field in error result");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o))
    else $error("stalled result dropped");

endmodule

bind hourly_five_node_thermal_step_unit hftsu_checker u_chk (.*);

`default_nettype wire
